// ===== rtl/bpu_pkg.sv =====
package bpu_pkg;

  localparam int COLOR_W     = 24;
  localparam int RADIUS_W    = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // bit positions inside the result tuser
  localparam int TUSER_NEW  = 0;
  localparam int TUSER_DROP = 1;
  localparam int TUSER_W    = 2;

  // one classified pixel on its way from the front to the back
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               cand;   // non-black and inside the circle
    logic               done;   // last pixel of the window
  } pix_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEARCH
  } back_state_t;

endpackage

// ===== rtl/bpu_ram.sv =====
module bpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bpu_front.sv =====
module bpu_front #(
  parameter int MAX_RADIUS = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bpu_pkg::RADIUS_W-1:0] cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bpu_pkg::COLOR_W-1:0]  s_tdata,
  output logic                         q_push,
  output bpu_pkg::pix_t                q_data,
  input  logic                         q_full
);

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int CW = $clog2(2 * MAX_RADIUS);
  localparam int DW = CW + 1;
  localparam int SW = 2 * DW;

  logic [bpu_pkg::RADIUS_W-1:0] brush_radius;
  logic [CW-1:0]                col, row, col_next, row_next;
  logic [RW-1:0]                r_eff;
  logic [RW:0]                  two_r;
  logic [CW-1:0]                edge_pos, x, y;
  logic signed [DW-1:0]         dx, dy;
  logic signed [SW-1:0]         dx_sq, dy_sq;
  logic [SW-1:0]                rr;
  logic                         at_end, s_acc, cfg_acc, in_circle;

  // stage register between the squares and the compare
  logic                         s1_valid;
  logic [bpu_pkg::COLOR_W-1:0]  s1_color;
  logic [SW-1:0]                s1_dx2, s1_dy2, s1_rr;
  logic                         s1_done;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign q_push    = s1_valid && !q_full;
  assign s_tready  = !s1_valid || q_push;
  assign s_acc     = s_tvalid && s_tready;

  always_comb begin
    if (brush_radius == '0) begin
      r_eff = RW'(1);
    end else if (32'(brush_radius) > 32'(MAX_RADIUS)) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(brush_radius);
    end
  end

  assign two_r    = {r_eff, 1'b0};
  assign edge_pos = CW'(two_r - 1'b1);
  assign x        = (col > edge_pos) ? edge_pos : col;
  assign y        = (row > edge_pos) ? edge_pos : row;
  assign dx       = $signed(DW'(x)) - $signed(DW'(r_eff));
  assign dy       = $signed(DW'(y)) - $signed(DW'(r_eff));
  assign dx_sq    = dx * dx;
  assign dy_sq    = dy * dy;
  assign rr       = SW'(r_eff) * SW'(r_eff);
  assign at_end   = (x >= edge_pos) && (y >= edge_pos);

  always_comb begin
    col_next = col;
    row_next = row;
    if (x >= edge_pos) begin
      col_next = '0;
      row_next = at_end ? '0 : CW'(y + 1'b1);
    end else begin
      col_next = CW'(x + 1'b1);
      row_next = y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_radius <= bpu_pkg::RADIUS_W'(8);
      col          <= '0;
      row          <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_acc) begin
        brush_radius <= cfg_data;
        col          <= '0;
        row          <= '0;
      end else if (s_acc) begin
        col <= col_next;
        row <= row_next;
      end
      if (s_acc) begin
        s1_valid <= 1'b1;
      end else if (q_push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_color <= s_tdata;
      s1_dx2   <= $unsigned(dx_sq);
      s1_dy2   <= $unsigned(dy_sq);
      s1_rr    <= rr;
      s1_done  <= at_end;
    end
  end

  assign in_circle = ({1'b0, s1_dx2} + {1'b0, s1_dy2}) < {1'b0, s1_rr};

  assign q_data.color = s1_color;
  assign q_data.cand  = (s1_color != '0) && in_circle;
  assign q_data.done  = s1_done;

endmodule

// ===== rtl/bpu_queue.sv =====
module bpu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpu_pkg::pix_t push_data,
  output logic          full,
  input  logic          pop,
  output bpu_pkg::pix_t pop_data,
  output logic          not_empty
);

  bpu_pkg::pix_t                 slots [bpu_pkg::QUEUE_DEPTH];
  logic [bpu_pkg::QUEUE_AW-1:0]  wr_ptr, rd_ptr;
  logic [bpu_pkg::QUEUE_CW-1:0]  count;

  assign full      = (count == bpu_pkg::QUEUE_CW'(bpu_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/bpu_back.sv =====
module bpu_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic                          q_valid,
  input  bpu_pkg::pix_t                 q_data,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bpu_pkg::COLOR_W-1:0]   m_tdata,
  output logic [bpu_pkg::TUSER_W-1:0]   m_tuser,
  output logic                          m_tlast
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  bpu_pkg::back_state_t         state, state_next;
  logic [FW-1:0]                fill;
  logic [AW-1:0]                k, k_next;
  bpu_pkg::pix_t                work;
  logic                         out_free, load, res_new, res_drop, res_done;
  logic [bpu_pkg::COLOR_W-1:0]  res_color;
  logic [AW-1:0]                raddr;
  logic [bpu_pkg::COLOR_W-1:0]  rdata;
  logic                         hit, last;

  bpu_ram #(
    .WIDTH (bpu_pkg::COLOR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (res_new),
    .waddr (AW'(fill)),
    .wdata (res_color),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !m_tvalid || m_tready;
  assign hit      = (rdata == work.color);
  assign last     = ((FW'(k) + FW'(1)) == fill);

  always_comb begin
    state_next = state;
    k_next     = k;
    q_pop      = 1'b0;
    raddr      = '0;
    load       = 1'b0;
    res_new    = 1'b0;
    res_drop   = 1'b0;
    res_done   = work.done;
    res_color  = work.color;
    case (state)
      bpu_pkg::BK_IDLE: begin
        res_done  = q_data.done;
        res_color = q_data.color;
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_data.cand && fill != '0) begin
            state_next = bpu_pkg::BK_SEARCH;
            k_next     = '0;
          end else begin
            load    = 1'b1;
            res_new = q_data.cand;
          end
        end
      end
      bpu_pkg::BK_SEARCH: begin
        raddr = AW'(k + 1'b1);
        if (hit) begin
          load       = 1'b1;
          state_next = bpu_pkg::BK_IDLE;
        end else if (last) begin
          load       = 1'b1;
          state_next = bpu_pkg::BK_IDLE;
          if (fill < FW'(TABLE_DEPTH)) begin
            res_new = 1'b1;
          end else begin
            res_drop = 1'b1;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      default: begin
        state_next = bpu_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bpu_pkg::BK_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (restart) begin
        fill <= '0;
      end else if (load && res_done) begin
        fill <= '0;
      end else if (res_new) begin
        fill <= fill + 1'b1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k <= k_next;
    if (q_pop) begin
      work <= q_data;
    end
    if (load) begin
      m_tdata                     <= res_new ? (res_color - 1'b1) : '0;
      m_tuser[bpu_pkg::TUSER_NEW]  <= res_new;
      m_tuser[bpu_pkg::TUSER_DROP] <= res_drop;
      m_tlast                     <= res_done;
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(TABLE_DEPTH))
    else $error("table fill beyond depth");

  a_search_out_empty: assert property (@(posedge clk) disable iff (rst)
    state == bpu_pkg::BK_SEARCH |-> !m_tvalid)
    else $error("result pending while searching");

  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == bpu_pkg::BK_SEARCH |-> fill != '0)
    else $error("search over empty table");

  a_new_xor_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[bpu_pkg::TUSER_NEW] && m_tuser[bpu_pkg::TUSER_DROP]))
    else $error("result both new and dropped");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    load && res_done |=> fill == '0)
    else $error("table not cleared after last pixel");
`endif

endmodule

// ===== rtl/brush_pick_unique_ids_core.sv =====
// Brush pick of unique ids. Pixels of a 2r x 2r id-buffer window arrive in raster
// order on s_*; the block counts column and row itself, keeps pixels with
// (x-r)^2 + (y-r)^2 < r^2, and reports each distinct non-black colour once per
// window as id = colour - 1. One result transaction leaves on m_* for every pixel
// transaction; tlast marks the last pixel of the window, after which the colour
// table and counters clear. A write on cfg_* sets the radius (0 acts as 1, values
// above MAX_RADIUS saturate) and restarts the scan; write it only while idle.
// Rate: the front classifies one pixel per cycle into a four-entry queue while
// the queue is not full. The back answers a pixel that is black, outside the
// circle, or meets an empty table straight from idle; for a candidate it searches
// the table RAM one entry per cycle through its single read port, over up to the n
// colours held, and pops no new pixel until the search ends. No clearing pass
// after reset: only entries below the fill count are ever compared.
module brush_pick_unique_ids_core #(
  parameter int TABLE_DEPTH = 64,   // distinct colours kept per window
  parameter int MAX_RADIUS  = 128   // largest radius honored
) (
  input  logic                         clk,
  input  logic                         rst,
  // radius register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bpu_pkg::RADIUS_W-1:0] cfg_data,    // [7:0] brush_radius
  // pixel stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bpu_pkg::COLOR_W-1:0]  s_tdata,     // [23:0] color
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [bpu_pkg::COLOR_W-1:0]  m_tdata,     // [23:0] picked_id
  output logic [bpu_pkg::TUSER_W-1:0]  m_tuser,     // [0] new_id_valid, [1] dropped_full
  output logic                         m_tlast      // scan_done
);

  bpu_pkg::pix_t push_data, pop_data;
  logic          push, full, pop, not_empty;

  // front: radius register, window counters, circle test
  bpu_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_push    (push),
    .q_data    (push_data),
    .q_full    (full)
  );

  // decouples the per-pixel front from the variable-length table search
  bpu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  // back: distinct-colour table lookup/insert and the result register
  bpu_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_valid && cfg_ready),
    .q_valid  (not_empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for brush_pick_unique_ids_core.
// A directed table runs first: reset default radius, radius 0, 1, 2 and a
// saturating write. Random phases follow, each with a new radius, a color mix
// and its own sender and receiver pacing. Known rows are scored against typed
// results, the rest by a local model of the circle test and distinct-color table.
module tb;

  localparam int TABLE_DEPTH  = 64;
  localparam int MAX_RADIUS   = 128;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int PIXEL_TARGET = 1325;  // directed plus about 1300 random
  localparam int TAIL_CYCLES  = 20;

  // one result transaction, fields in model order
  typedef struct packed {
    logic                        new_id;
    logic [bpu_pkg::COLOR_W-1:0] id;
    logic                        dropped;
    logic                        last;
  } pick_result_t;

  typedef enum logic [1:0] {
    ROW_PIXEL,    // scored by the model
    ROW_KNOWN,    // result typed into the table
    ROW_RADIUS    // radius register write
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [bpu_pkg::COLOR_W-1:0] value;
    pick_result_t                want;
  } stim_row_t;

  typedef enum int {
    COLOR_PALETTE,  // few colors plus black, lots of repeats
    COLOR_WIDE,     // full 24-bit random, fills the table
    COLOR_CORNER    // black, 1, all ones, walking bits
  } color_mode_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [bpu_pkg::RADIUS_W-1:0] cfg_data;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [bpu_pkg::COLOR_W-1:0]  s_tdata;    // [23:0] color
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [bpu_pkg::COLOR_W-1:0]  m_tdata;    // [23:0] picked_id
  logic [bpu_pkg::TUSER_W-1:0]  m_tuser;    // [0] new_id_valid, [1] dropped_full
  logic                         m_tlast;    // scan_done

  brush_pick_unique_ids_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_RADIUS  (MAX_RADIUS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model state: radius register, scan counters and the distinct-color table
  // ---------------------------------------------------------------------------
  logic [bpu_pkg::RADIUS_W-1:0] model_radius;
  logic [7:0]                   model_col;
  logic [7:0]                   model_row;
  logic [bpu_pkg::COLOR_W-1:0]  model_colors [TABLE_DEPTH];
  logic [6:0]                   model_fill;

  pick_result_t pending_results [$];

  int mismatch_count = 0;
  int pixels_sent    = 0;
  int radius_writes  = 0;
  int windows_done   = 0;
  int ids_seen       = 0;
  int drops_seen     = 0;

  // receiver pacing, changed by the stimulus process with NBAs only
  int          ready_mode    = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  pattern_pos   = '0;
  int          stall_left    = 0;

  // sender pacing
  int burst_left;
  bit steady_send;
  logic [bpu_pkg::COLOR_W-1:0] palette [6];

  // zero acts as one, anything above the maximum saturates
  function automatic int brush_r(input logic [bpu_pkg::RADIUS_W-1:0] reg_val);
    if (reg_val == 0) return 1;
    if (reg_val > MAX_RADIUS) return MAX_RADIUS;
    return int'(reg_val);
  endfunction

  task automatic predict_pixel(input logic [bpu_pkg::COLOR_W-1:0] color,
                               output pick_result_t res);
    int r, last_pos, x, y, dx, dy;
    bit seen;
    res      = '0;
    r        = brush_r(model_radius);
    last_pos = 2 * r - 1;
    // a counter past the window edge counts as sitting on the edge
    x  = (model_col > last_pos) ? last_pos : int'(model_col);
    y  = (model_row > last_pos) ? last_pos : int'(model_row);
    dx = x - r;
    dy = y - r;
    if (color != 0 && dx * dx + dy * dy < r * r) begin
      seen = 1'b0;
      for (int k = 0; k < model_fill; k++) begin
        if (model_colors[k] == color) seen = 1'b1;
      end
      if (!seen) begin
        if (model_fill < TABLE_DEPTH) begin
          model_colors[model_fill] = color;
          model_fill               = model_fill + 7'd1;
          res.new_id               = 1'b1;
          res.id                   = color - 24'd1;
        end else begin
          // table full: lost again every time it shows up
          res.dropped = 1'b1;
        end
      end
    end
    if (x >= last_pos) begin
      if (y >= last_pos) begin
        res.last   = 1'b1;
        model_col  = '0;
        model_row  = '0;
        model_fill = '0;
      end else begin
        model_col = '0;
        model_row = 8'(y + 1);
      end
    end else begin
      model_col = 8'(x + 1);
      model_row = 8'(y);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving side. All inputs change by NBA at a rising edge.
  // ---------------------------------------------------------------------------
  task automatic drive_pixel(input logic [bpu_pkg::COLOR_W-1:0] color, input bit typed,
                             input pick_result_t typed_res);
    pick_result_t res;
    predict_pixel(color, res);
    if (typed) res = typed_res;
    pending_results = {pending_results, res};
    s_tvalid <= 1'b1;
    s_tdata  <= color;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // bursts of random length, random gaps in between, now and then a long one
  task automatic paced_pixel(input logic [bpu_pkg::COLOR_W-1:0] color);
    int gap;
    if (burst_left == 0) begin
      if (steady_send) gap = 0;
      else if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 40);
      else gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    drive_pixel(color, 1'b0, '0);
  endtask

  // hold the sender until every pending result is out; checked at the falling
  // edge so the scoreboard pop at the rising edge has settled
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // a radius write also restarts the scan
  task automatic write_radius(input logic [bpu_pkg::RADIUS_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    model_radius  = value;
    model_col     = '0;
    model_row     = '0;
    model_fill    = '0;
    radius_writes++;
  endtask

  function automatic logic [bpu_pkg::COLOR_W-1:0] phase_color(input color_mode_t mode);
    logic [31:0] w;
    int k;
    w = $urandom;
    k = $urandom_range(0, bpu_pkg::COLOR_W - 1);
    case (mode)
      COLOR_PALETTE: begin
        if ($urandom_range(0, 7) == 0) return '0;
        return palette[$urandom_range(0, 5)];
      end
      COLOR_WIDE: return w[bpu_pkg::COLOR_W-1:0];
      default: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 24'h000001;
          2: return 24'hFFFFFF;
          3: return 24'h000001 << k;
          default: return ~(24'h000001 << k);
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall patterns picked per phase
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: begin
        m_tready    <= stall_pattern[pattern_pos];
        pattern_pos <= pattern_pos + 4'd1;
      end
      default: begin
        // mostly ready, with occasional stalls whose length stall_left counts down
        if (stall_left != 0) begin
          m_tready   <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 20);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what,
                                 input logic [bpu_pkg::COLOR_W-1:0] got,
                                 input logic [bpu_pkg::COLOR_W-1:0] want);
    $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    pick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, picked_id", m_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser[bpu_pkg::TUSER_NEW] !== want.new_id)
          report_mismatch("new_id_valid",
                          {{(bpu_pkg::COLOR_W-1){1'b0}}, m_tuser[bpu_pkg::TUSER_NEW]},
                          {{(bpu_pkg::COLOR_W-1){1'b0}}, want.new_id});
        if (m_tdata !== want.id)
          report_mismatch("picked_id", m_tdata, want.id);
        if (m_tuser[bpu_pkg::TUSER_DROP] !== want.dropped)
          report_mismatch("dropped_full",
                          {{(bpu_pkg::COLOR_W-1){1'b0}}, m_tuser[bpu_pkg::TUSER_DROP]},
                          {{(bpu_pkg::COLOR_W-1){1'b0}}, want.dropped});
        if (m_tlast !== want.last)
          report_mismatch("scan_done", {{(bpu_pkg::COLOR_W-1){1'b0}}, m_tlast},
                          {{(bpu_pkg::COLOR_W-1){1'b0}}, want.last});
      end
      if (m_tuser[bpu_pkg::TUSER_NEW] === 1'b1) ids_seen++;
      if (m_tuser[bpu_pkg::TUSER_DROP] === 1'b1) drops_seen++;
      if (m_tlast === 1'b1) windows_done++;
    end
  end

  // watchdog: any transaction on any channel clears it
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               IDLE_LIMIT, pending_results.size());
      $display("brush_pick_unique_ids_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t directed [$];

  function automatic void add_row(input row_kind_t kind,
                                  input logic [bpu_pkg::COLOR_W-1:0] value,
                                  input pick_result_t want);
    stim_row_t row;
    row.kind  = kind;
    row.value = value;
    row.want  = want;
    directed  = {directed, row};
  endfunction

  initial begin : stimulus
    int sel, r_eff, win, count, pause_at, phase;
    logic [bpu_pkg::RADIUS_W-1:0] radius_val;
    logic [31:0] w;
    color_mode_t mode;

    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;

    model_radius = 8'd8;
    model_col    = '0;
    model_row    = '0;
    model_fill   = '0;
    burst_left   = 0;
    steady_send  = 1'b1;

    // radius 8 after reset: first pixel is a window corner, outside the circle
    add_row(ROW_KNOWN, 24'h123456, '0);
    // radius 0 acts as 1: 2x2 window, only the last pixel is inside
    add_row(ROW_RADIUS, 24'd0, '0);
    add_row(ROW_KNOWN, 24'hFFFFFF, '0);
    add_row(ROW_KNOWN, 24'h000001, '0);
    add_row(ROW_KNOWN, 24'h000002, '0);
    add_row(ROW_KNOWN, 24'hFFFFFF, '{1'b1, 24'hFFFFFE, 1'b0, 1'b1});
    // next window: black inside the circle only ends the scan
    add_row(ROW_KNOWN, 24'h800000, '0);
    add_row(ROW_KNOWN, 24'h000005, '0);
    add_row(ROW_KNOWN, 24'h000007, '0);
    add_row(ROW_KNOWN, 24'h000000, '{1'b0, 24'h000000, 1'b0, 1'b1});
    // radius 1: color 1 gives id 0
    add_row(ROW_RADIUS, 24'd1, '0);
    add_row(ROW_KNOWN, 24'h0000FF, '0);
    add_row(ROW_KNOWN, 24'h00FF00, '0);
    add_row(ROW_KNOWN, 24'hFF0000, '0);
    add_row(ROW_KNOWN, 24'h000001, '{1'b1, 24'h000000, 1'b0, 1'b1});
    // radius 2, partial window: repeats, black inside, outside pixels
    add_row(ROW_RADIUS, 24'd2, '0);
    repeat (4) add_row(ROW_PIXEL, 24'hABCDEF, '0);
    add_row(ROW_PIXEL, 24'h555555, '0);
    add_row(ROW_PIXEL, 24'hABCDEF, '0);
    add_row(ROW_PIXEL, 24'hABCDEF, '0);
    add_row(ROW_PIXEL, 24'h000000, '0);
    add_row(ROW_PIXEL, 24'h555555, '0);
    add_row(ROW_PIXEL, 24'h555555, '0);
    add_row(ROW_PIXEL, 24'hABCDEF, '0);
    // 255 saturates to the maximum radius; the scan restarts at the corner
    add_row(ROW_RADIUS, 24'd255, '0);
    add_row(ROW_KNOWN, 24'hFFFFFF, '0);

    repeat (7) @(posedge clk);
    rst        <= 1'b0;
    ready_mode <= 1;

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_RADIUS: write_radius(directed[i].value[bpu_pkg::RADIUS_W-1:0]);
        ROW_KNOWN:  drive_pixel(directed[i].value, 1'b1, directed[i].want);
        default:    drive_pixel(directed[i].value, 1'b0, '0);
      endcase
    end

    // random phases: one radius each, mostly whole windows of small radius
    phase = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      if (phase == 0) begin
        radius_val = 8'd128;
      end else begin
        sel = $urandom_range(0, 19);
        case (sel)
          0:          radius_val = 8'd0;
          1:          radius_val = 8'd255;
          2, 3, 4, 5: radius_val = 8'd6;     // enough pixels to overflow the table
          6, 7:       radius_val = 8'($urandom_range(7, 20));
          default:    radius_val = 8'($urandom_range(1, 5));
        endcase
      end
      write_radius(radius_val);

      r_eff = brush_r(radius_val);
      win   = 4 * r_eff * r_eff;
      if (r_eff >= 5 && $urandom_range(0, 1) == 1) mode = COLOR_WIDE;
      else mode = color_mode_t'($urandom_range(0, 2));
      for (int i = 0; i < 6; i++) begin
        w          = $urandom;
        palette[i] = ($urandom_range(0, 3) == 0) ? {16'h0000, w[7:0]}
                                                 : w[bpu_pkg::COLOR_W-1:0];
      end

      ready_mode    <= $urandom_range(0, 3);
      stall_pattern <= 16'($urandom) | 16'h0001;
      steady_send    = ($urandom_range(0, 3) == 0);
      burst_left     = 0;

      if (win > 1600) begin
        // largest radius: a couple of rows reach into the circle
        count = $urandom_range(300, 520);
      end else begin
        count = win * ((win > 150) ? 1 : $urandom_range(1, 3));
        // now and then a window cut short by the next radius write
        if ($urandom_range(0, 3) == 0) count += $urandom_range(1, win - 1);
      end
      // keep the total near the target
      if (count > PIXEL_TARGET - pixels_sent) count = PIXEL_TARGET - pixels_sent;
      pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1;

      for (int i = 0; i < count; i++) begin
        if (i == pause_at) drain_results();
        paced_pixel(phase_color(mode));
      end
      phase++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d pixel transactions in %0d radius settings, %0d windows closed",
             pixels_sent, radius_writes, windows_done);
    $display("summary: %0d new ids, %0d table-full drops, %0d mismatches",
             ids_seen, drops_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("brush_pick_unique_ids_core regression: pass");
    end else begin
      $display("brush_pick_unique_ids_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bpu_pkg.sv
rtl/bpu_ram.sv
rtl/bpu_front.sv
rtl/bpu_queue.sv
rtl/bpu_back.sv
rtl/brush_pick_unique_ids_core.sv
tb/tb.sv
